// ----- rtl/spwt_pkg.sv -----
// Shared types, constants and state codes for the shortest path unit.
package spwt_pkg;

	localparam int unsigned NODE_W  = 6;
	localparam int unsigned COST_W  = 22;
	localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  from_node;
		logic [5:0]  to_node;
		logic [15:0] edge_weight;
		logic [7:0]  route_id;
		logic [5:0]  start_node;
		logic [5:0]  end_node;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [5:0]  path_node;
		logic        has_route;
		logic [7:0]  arrival_route;
		logic [21:0] total_cost;
		logic [6:0]  visited_count;
		logic [5:0]  transfers;
		logic        last;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_INIT,
		S_SCAN_RD,
		S_SCAN,
		S_SCAN_END,
		S_SETTLE,
		S_EDGE_RD,
		S_EDGE,
		S_EDGE_WR,
		S_WALK_RD,
		S_WALK,
		S_TR_RD,
		S_TR_NODE,
		S_TR,
		S_EMIT_RD,
		S_EMIT_NODE,
		S_EMIT,
		S_SIMPLE,
		S_WAIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic do_load;
		logic do_clear;
		logic init_query;
		logic scan_reset;
		logic scan_rd;
		logic scan_step;
		logic settle;
		logic edge_reset;
		logic edge_rd;
		logic edge_eval;
		logic edge_write;
		logic edge_next;
		logic walk_init;
		logic walk_rd;
		logic walk_step;
		logic tr_init;
		logic tr_rd;
		logic tr_step;
		logic emit_init;
		logic emit_rd;
		logic emit_path;
		logic emit_simple;
		logic emit_next;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       query_bad;
		logic       query_same;
		logic       scan_done;
		logic       none_found;
		logic       is_target;
		logic       edge_done;
		logic       edge_hit;
		logic       edge_upd;
		logic       walk_done;
		logic       tr_done;
		logic       emit_done;
		logic       out_busy;
	} stat_t;

endpackage

// ----- rtl/spwt_ram.sv -----
// Generic single-port RAM with registered read data.
module spwt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/spwt_ctrl.sv -----
// Controller state machine that sequences loads, searches and path output.
module spwt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  spwt_pkg::stat_t st,
	output spwt_pkg::cmd_t  cmd
);
	import spwt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.mode)
					MODE_LOAD: begin
						if (!st.out_busy) begin
							cmd.do_load = 1'b1;
							state_d = S_IDLE;
						end
					end
					MODE_CLEAR: begin
						if (!st.out_busy) begin
							cmd.do_clear = 1'b1;
							state_d = S_IDLE;
						end
					end
					MODE_QUERY: begin
						if (st.query_bad || st.query_same) begin
							state_d = S_SIMPLE;
						end else begin
							cmd.init_query = 1'b1;
							state_d = S_INIT;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_INIT: begin
				cmd.scan_reset = 1'b1;
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				state_d = st.scan_done ? S_SCAN_END : S_SCAN_RD;
			end
			S_SCAN_END: begin
				if (st.none_found) begin
					state_d = S_SIMPLE;
				end else begin
					state_d = S_SETTLE;
				end
			end
			S_SETTLE: begin
				cmd.settle = 1'b1;
				cmd.edge_reset = 1'b1;
				state_d = st.is_target ? S_WALK_RD : S_EDGE_RD;
				if (st.is_target) begin
					cmd.walk_init = 1'b1;
				end
			end
			S_EDGE_RD: begin
				if (st.edge_done) begin
					cmd.scan_reset = 1'b1;
					state_d = S_SCAN_RD;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d = S_EDGE;
				end
			end
			S_EDGE: begin
				cmd.edge_eval = 1'b1;
				state_d = st.edge_hit ? S_EDGE_WR : S_EDGE_RD;
				if (!st.edge_hit) begin
					cmd.edge_next = 1'b1;
				end
			end
			S_EDGE_WR: begin
				// The cost of the target node has just arrived from the node table.
				cmd.edge_write = st.edge_upd;
				cmd.edge_next = 1'b1;
				state_d = S_EDGE_RD;
			end
			S_WALK_RD: begin
				if (st.walk_done) begin
					cmd.tr_init = 1'b1;
					state_d = S_TR_RD;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				state_d = S_WALK_RD;
			end
			S_TR_RD: begin
				if (st.tr_done) begin
					cmd.emit_init = 1'b1;
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_TR_NODE;
				end
			end
			S_TR_NODE: begin
				cmd.tr_rd = 1'b1;
				state_d = S_TR;
			end
			S_TR: begin
				cmd.tr_step = 1'b1;
				state_d = S_TR_RD;
			end
			S_EMIT_RD: begin
				if (!st.out_busy) begin
					state_d = S_EMIT_NODE;
				end
			end
			S_EMIT_NODE: begin
				cmd.emit_rd = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_path = 1'b1;
				state_d = st.emit_done ? S_IDLE : S_EMIT_RD;
				cmd.emit_next = 1'b1;
			end
			S_SIMPLE: begin
				if (!st.out_busy) begin
					cmd.emit_simple = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- rtl/spwt_dp.sv -----
// Datapath: edge store, cost tables, masks, path buffer and output register.
module spwt_dp #(
	parameter int unsigned MAX_NODES   = 64,
	parameter int unsigned MAX_EDGES   = 256,
	parameter int unsigned WEIGHT_BITS = 16,
	parameter int unsigned ROUTE_BITS  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spwt_pkg::in_item_t  in_item,
	input  logic [6:0]          node_count,
	input  spwt_pkg::cmd_t      cmd,
	output spwt_pkg::stat_t     st,
	output logic                out_valid,
	input  logic                out_stall,
	output spwt_pkg::out_item_t out_item
);
	import spwt_pkg::*;

	localparam int unsigned NI_W = $clog2(MAX_NODES);
	localparam int unsigned EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned EF_W = $clog2(MAX_EDGES + 1);
	localparam int unsigned E_W  = 2 * NODE_W + WEIGHT_BITS + ROUTE_BITS;
	localparam int unsigned NC_W = NI_W + 1;

	in_item_t           it_q;
	logic [EF_W-1:0]    fill_q;
	logic [MAX_NODES-1:0] reached_q, settled_q;
	logic [NC_W-1:0]    n_eff;
	logic [NC_W-1:0]    scan_i_q;
	logic [NI_W-1:0]    best_i_q, u_q;
	logic               best_v_q;
	logic [COST_W-1:0]  best_c_q, cu_q;
	logic [EF_W-1:0]    e_q;
	logic [6:0]         visited_q;
	logic [NODE_W-1:0]  ev_q;
	logic [COST_W-1:0]  sum_q;
	logic [ROUTE_BITS-1:0] er_q;
	logic               upd_q;
	logic [NI_W-1:0]    cur_q;
	logic [NC_W-1:0]    len_q, pi_q;
	logic               walk_done_q;
	logic [ROUTE_BITS-1:0] prev_r_q;
	logic [5:0]         trans_q;
	logic [COST_W-1:0]  total_q;
	logic               ov_q;
	out_item_t          oi_q;
	out_item_t          oi_d;

	// Edge store.
	logic            e_we;
	logic [EI_W-1:0] e_addr;
	logic [E_W-1:0]  e_wd, e_rd;
	// Node tables: cost, predecessor and predecessor route share one address.
	logic               n_we;
	logic [NI_W-1:0]    n_addr;
	logic [COST_W+NI_W+ROUTE_BITS-1:0] n_wd, n_rd;
	logic               p_we;
	logic [NI_W-1:0]    p_addr;
	logic [NI_W-1:0]    p_wd, p_rd;

	spwt_ram #(.WIDTH(E_W), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
	spwt_ram #(.WIDTH(COST_W + NI_W + ROUTE_BITS), .DEPTH(MAX_NODES)) u_nodes (
		.clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));
	spwt_ram #(.WIDTH(NI_W), .DEPTH(MAX_NODES)) u_path (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));

	logic [COST_W-1:0]     rd_cost;
	logic [NI_W-1:0]       rd_pred;
	logic [ROUTE_BITS-1:0] rd_route;
	assign {rd_cost, rd_pred, rd_route} = n_rd;

	logic [NODE_W-1:0]      ed_from, ed_to;
	logic [WEIGHT_BITS-1:0] ed_w;
	logic [ROUTE_BITS-1:0]  ed_r;
	assign {ed_from, ed_to, ed_w, ed_r} = e_rd;

	assign n_eff = (node_count > 7'(MAX_NODES)) ? NC_W'(MAX_NODES) : NC_W'(node_count);

	logic from_bad, to_bad, s_bad, t_bad;
	assign from_bad = {1'b0, it_q.from_node} >= 7'(n_eff);
	assign to_bad   = {1'b0, it_q.to_node}   >= 7'(n_eff);
	assign s_bad    = {1'b0, it_q.start_node} >= 7'(n_eff);
	assign t_bad    = {1'b0, it_q.end_node}   >= 7'(n_eff);

	logic [NI_W-1:0] s_i, t_i, si_i;
	assign s_i  = it_q.start_node[NI_W-1:0];
	assign t_i  = it_q.end_node[NI_W-1:0];
	assign si_i = scan_i_q[NI_W-1:0];

	// Edge evaluation signals.
	logic        e_hit;
	logic [COST_W:0] sum_w;
	assign e_hit = (ed_from == NODE_W'(u_q)) && ({1'b0, ed_to} < 7'(n_eff))
		&& !settled_q[ed_to[NI_W-1:0]];
	assign sum_w = {1'b0, cu_q} + (COST_W+1)'(ed_w);

	// Memory port muxing.
	always_comb begin
		e_we   = cmd.do_load && !from_bad && !to_bad && (fill_q < EF_W'(MAX_EDGES));
		e_addr = cmd.do_load ? fill_q[EI_W-1:0] : e_q[EI_W-1:0];
		e_wd   = {it_q.from_node, it_q.to_node, WEIGHT_BITS'(it_q.edge_weight),
			ROUTE_BITS'(it_q.route_id)};
		n_we   = 1'b0;
		n_addr = si_i;
		n_wd   = {sum_q, u_q, er_q};
		if (cmd.init_query) begin
			n_we   = 1'b1;
			n_addr = s_i;
			n_wd   = '0;
		end else if (cmd.edge_eval) begin
			n_addr = ed_to[NI_W-1:0];
		end else if (cmd.edge_write) begin
			n_we   = 1'b1;
			n_addr = ev_q[NI_W-1:0];
		end else if (cmd.walk_rd || cmd.settle) begin
			n_addr = cur_q;
		end else if (cmd.tr_rd || cmd.emit_rd) begin
			n_addr = p_rd;
		end
		p_we   = cmd.walk_step;
		p_addr = cmd.walk_step ? len_q[NI_W-1:0] : pi_q[NI_W-1:0];
		p_wd   = cur_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			it_q <= in_item;
		end
		if (cmd.scan_reset) begin
			scan_i_q <= '0;
			best_v_q <= 1'b0;
		end
		if (cmd.scan_step) begin
			scan_i_q <= scan_i_q + 1'b1;
			if (reached_q[si_i] && !settled_q[si_i] &&
			    (!best_v_q || rd_cost < best_c_q)) begin
				best_v_q <= 1'b1;
				best_i_q <= si_i;
				best_c_q <= rd_cost;
			end
		end
		if (cmd.settle) begin
			u_q  <= best_i_q;
			cu_q <= best_c_q;
			cur_q <= t_i;
			total_q <= best_c_q;
		end
		if (cmd.edge_reset) begin
			e_q <= '0;
		end
		if (cmd.edge_next) begin
			e_q <= e_q + 1'b1;
		end
		if (cmd.edge_eval) begin
			ev_q  <= ed_to;
			sum_q <= sum_w[COST_W] ? COST_MAX :
				((sum_w[COST_W-1:0] > COST_MAX) ? COST_MAX : sum_w[COST_W-1:0]);
			er_q  <= ed_r;
		end
		if (cmd.walk_init) begin
			len_q <= '0;
			walk_done_q <= 1'b0;
		end
		if (cmd.walk_step) begin
			len_q <= len_q + 1'b1;
			if (cur_q == s_i) begin
				walk_done_q <= 1'b1;
			end else if (len_q == NC_W'(MAX_NODES - 2)) begin
				// Buffer full: the start node takes the last slot.
				cur_q <= s_i;
			end else begin
				cur_q <= rd_pred;
			end
		end
		if (cmd.tr_init) begin
			pi_q    <= '0;
			trans_q <= '0;
		end
		if (cmd.tr_step) begin
			pi_q <= pi_q + 1'b1;
			prev_r_q <= rd_route;
			if (pi_q != '0 && prev_r_q != rd_route) begin
				trans_q <= trans_q + 1'b1;
			end
		end
		if (cmd.emit_init) begin
			pi_q <= len_q - 1'b1;
		end
		if (cmd.emit_next) begin
			pi_q <= pi_q - 1'b1;
		end
	end

	// Walk back pass: the start node ends the walk.
	// Transfer pass compares routes of path entries i and i+1 for i+2 < len.
	logic tr_done;
	assign tr_done = (pi_q + 2'd2 > len_q) || (pi_q + 1'b1 >= len_q);

	always_ff @(posedge clk) begin
		if (cmd.edge_eval) begin
			upd_q <= !reached_q[ed_to[NI_W-1:0]];
		end
		if (cmd.edge_write) begin
			upd_q <= upd_q;
		end
	end

	logic cmp_lt;
	assign cmp_lt = sum_q < rd_cost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			reached_q <= '0;
			settled_q <= '0;
			visited_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (e_we) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.do_clear) begin
				fill_q <= '0;
			end
			if (cmd.init_query) begin
				reached_q <= {{(MAX_NODES-1){1'b0}}, 1'b1} << s_i;
				settled_q <= '0;
				visited_q <= '0;
			end
			if (cmd.settle) begin
				settled_q[best_i_q] <= 1'b1;
				visited_q <= visited_q + 1'b1;
			end
			if (cmd.edge_write) begin
				reached_q[ev_q[NI_W-1:0]] <= 1'b1;
			end
			if (cmd.do_load || cmd.do_clear || cmd.emit_simple || cmd.emit_path) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_comb begin
		oi_d = oi_q;
		if (cmd.do_load || cmd.do_clear) begin
			oi_d = '0;
			if (cmd.do_load) begin
				oi_d.status = from_bad || to_bad ? ST_INVALID :
					(fill_q >= EF_W'(MAX_EDGES) ? ST_FULL : ST_OK);
			end
			oi_d.last = 1'b1;
		end
		if (cmd.emit_simple) begin
			oi_d = '0;
			oi_d.last = 1'b1;
			if (s_bad || t_bad) begin
				oi_d.status = ST_INVALID;
			end else if (it_q.start_node == it_q.end_node) begin
				oi_d.found = 1'b1;
				oi_d.path_node = it_q.start_node;
			end else begin
				oi_d.visited_count = visited_q;
			end
		end
		if (cmd.emit_path) begin
			oi_d.status        = ST_OK;
			oi_d.found         = 1'b1;
			oi_d.path_node     = NODE_W'(p_rd);
			oi_d.has_route     = (pi_q != len_q - 1'b1);
			oi_d.arrival_route = (pi_q != len_q - 1'b1) ? 8'(rd_route) : 8'd0;
			oi_d.total_cost    = total_q;
			oi_d.visited_count = visited_q;
			oi_d.transfers     = trans_q;
			oi_d.last          = (pi_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		oi_q <= oi_d;
	end

	assign out_valid = ov_q;
	assign out_item  = oi_q;

	assign st.mode       = it_q.mode;
	assign st.query_bad  = s_bad || t_bad;
	assign st.query_same = it_q.start_node == it_q.end_node;
	assign st.scan_done  = (scan_i_q + 1'b1) >= n_eff;
	assign st.none_found = !best_v_q;
	assign st.is_target  = best_i_q == t_i;
	assign st.edge_done  = (e_q >= fill_q);
	assign st.edge_hit   = e_hit;
	assign st.edge_upd   = upd_q || cmp_lt;
	assign st.walk_done  = walk_done_q;
	assign st.tr_done    = tr_done;
	assign st.emit_done  = (pi_q == '0);
	assign st.out_busy   = ov_q && out_stall;
endmodule

// ----- rtl/shortest_path_with_transfers_unit.sv -----
// Top level of the shortest path unit with route transfer counting.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid/in_stall     spwt_pkg::in_item_t
// out       output     out_valid/out_stall   spwt_pkg::out_item_t
// cfg       input      cfg_valid/cfg_ready   node_count write data
//
// A load or clear is accepted in S_IDLE and carried out in S_DECODE once the
// output is free. A query settles one node per round: each round scans all
// active nodes through the node table port and, unless the settled node is the
// target, then walks the whole edge store, relaxing the edges that leave the
// settled node. It ends with a path walk, a transfer count and the emission of
// the path nodes. Reset clears the edge count, the masks and the output valid
// flag and sets node_count to 64. A stall on the output holds the result
// register and the controller waits for it.
module shortest_path_with_transfers_unit #(
	parameter int unsigned MAX_NODES   = 64,
	parameter int unsigned MAX_EDGES   = 256,
	parameter int unsigned WEIGHT_BITS = 16,
	parameter int unsigned ROUTE_BITS  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  spwt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output spwt_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [6:0]          cfg_data
);
	import spwt_pkg::*;

	logic [6:0] node_count_q;
	cmd_t  cmd;
	stat_t st;

	// The register is taken whenever the port offers a transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 7'd64;
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	spwt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.st(st), .cmd(cmd));

	spwt_dp #(
		.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES),
		.WEIGHT_BITS(WEIGHT_BITS), .ROUTE_BITS(ROUTE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .node_count(node_count_q),
		.cmd(cmd), .st(st), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_data));
endmodule

// ----- rtl/spwt_checker.sv -----
// Port-level checker for the shortest path unit, bound to the top level.
module spwt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input spwt_pkg::out_item_t out_data
);
	import spwt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before the first was decoded");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("undefined status code");

	a_fail_no_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> !out_data.found && out_data.last)
		else $error("error result carries a path");
endmodule

bind shortest_path_with_transfers_unit spwt_checker u_spwt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
